/* hdl/shac_pkg.sv */
// Shared types, constants and hash functions for the SHA-512 compression core.
// Used by every module in hdl/; depends on nothing else.
package shac_pkg;

  localparam int WORD_W       = 64;
  localparam int BLOCK_WORDS  = 16;
  localparam int POS_W        = $clog2(BLOCK_WORDS);
  localparam int ROUNDS       = 80;
  localparam int ROUND_W      = $clog2(ROUNDS);
  localparam int DIGEST_WORDS = 8;
  localparam int DIGEST_W     = $clog2(DIGEST_WORDS);
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t message_word;
    logic  new_message;
    logic  final_block;
  } in_req_t;

  typedef struct packed {
    word_t                digest_word;
    logic [DIGEST_W-1:0]  digest_index;
    logic                 digest_last;
  } out_rsp_t;

  // One classified request as it travels from the front end to the engine.
  typedef struct packed {
    word_t word;
    logic  reload;
    logic  compress;
    logic  emit;
  } cmd_t;

  // Message schedule controls: load shifts in a message word, step expands one word.
  typedef struct packed {
    logic load;
    logic step;
  } sched_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } eng_state_t;

  localparam word_t IV [DIGEST_WORDS] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  // Round constants; indexes past the last round read as zero.
  function automatic word_t round_k(input logic [ROUND_W-1:0] idx);
    word_t k;
    unique case (idx)
      7'd0:  k = 64'h428a2f98d728ae22;
      7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;
      7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;
      7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;
      7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;
      7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;
      7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;
      7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;
      7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;
      7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;
      7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;
      7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;
      7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;
      7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;
      7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;
      7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;
      7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;
      7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;
      7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;
      7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;
      7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;
      7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;
      7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;
      7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;
      7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;
      7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;
      7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;
      7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;
      7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;
      7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;
      7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;
      7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;
      7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;
      7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;
      7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;
      7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;
      7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;
      7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;
      7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;
      7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

/* hdl/shac_front.sv */
// Front end of the SHA-512 compression core: tracks word position and queues requests.
// Depends on shac_pkg.
module shac_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  shac_pkg::in_req_t in_data,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output shac_pkg::cmd_t cmd
);
  import shac_pkg::*;

  logic [POS_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] pos;
  cmd_t             q_r [QDEPTH];
  cmd_t             entry;
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r, count_nxt;
  logic             push, pop, last_pos;

  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign in_ready  = (count_r != (QAW+1)'(QDEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  // A new message restarts the block at this word.
  assign pos      = in_data.new_message ? '0 : cnt_r;
  assign last_pos = (pos == POS_W'(BLOCK_WORDS - 1));
  assign cnt_nxt  = pos + POS_W'(1);

  always_comb begin
    entry.word     = in_data.message_word;
    entry.reload   = in_data.new_message;
    entry.compress = last_pos;
    entry.emit     = last_pos && in_data.final_block;
  end

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + (QAW+1)'(1);
      2'b01:   count_nxt = count_r - (QAW+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        cnt_r    <= cnt_nxt;
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH))
    else $error("request queue count exceeds depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    QAW'(wr_ptr_r - rd_ptr_r) == count_r[QAW-1:0])
    else $error("request queue pointers disagree with count");

endmodule

/* hdl/shac_sched.sv */
// Message schedule window of the SHA-512 compression core: a 16-word shift line.
// Depends on shac_pkg.
module shac_sched (
  input  logic                clk,
  input  shac_pkg::sched_ctl_t ctl,
  input  shac_pkg::word_t     word_in,
  output shac_pkg::word_t     w0,
  output shac_pkg::word_t     w1
);
  import shac_pkg::*;

  word_t w_r [BLOCK_WORDS];
  word_t w_new;

  // Word sixteen places ahead of the head, from the taps of the window.
  assign w_new = small_sigma1(w_r[14]) + w_r[9] + small_sigma0(w_r[1]) + w_r[0];
  assign w0    = w_r[0];
  assign w1    = w_r[1];

  always_ff @(posedge clk) begin
    if (ctl.load || ctl.step) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[BLOCK_WORDS-1] <= ctl.load ? word_in : w_new;
    end
  end

endmodule

/* hdl/shac_engine.sv */
// Back end of the SHA-512 compression core: round engine, chaining value and digest output.
// Depends on shac_pkg; drives the schedule window in shac_sched.
module shac_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  shac_pkg::cmd_t       cmd,
  output shac_pkg::sched_ctl_t sched_ctl,
  input  shac_pkg::word_t      w0,
  input  shac_pkg::word_t      w1,
  output logic                 out_valid,
  input  logic                 out_ready,
  output shac_pkg::out_rsp_t   out_data
);
  import shac_pkg::*;

  eng_state_t          state_r, state_nxt;
  logic [ROUND_W-1:0]  round_r;
  logic [DIGEST_W-1:0] idx_r;
  logic                emit_r;
  word_t               chain_r [DIGEST_WORDS];
  word_t               v_r [DIGEST_WORDS];
  word_t               hkw_r;
  logic                out_valid_r;
  out_rsp_t            out_data_r;
  logic                pop, slot_free, emit_load, last_round, last_idx;
  word_t               ch, maj, t1, t2;

  assign pop        = cmd_valid && cmd_ready;
  assign slot_free  = !out_valid_r || out_ready;
  assign last_round = (round_r == ROUND_W'(ROUNDS - 1));
  assign last_idx   = (idx_r == DIGEST_W'(DIGEST_WORDS - 1));
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // h + K + W is prepared one round ahead, so T1 needs only a three-input add.
  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = hkw_r + big_sigma1(v_r[4]) + ch;
  assign t2  = big_sigma0(v_r[0]) + maj;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop && cmd.compress) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (last_round) state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        state_nxt = emit_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (slot_free && last_idx) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready      = 1'b0;
    sched_ctl.load = 1'b0;
    sched_ctl.step = 1'b0;
    emit_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd_ready      = 1'b1;
        sched_ctl.load = cmd_valid;
      end
      ST_ROUND: begin
        sched_ctl.step = 1'b1;
      end
      ST_EMIT: begin
        emit_load = slot_free;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      idx_r       <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
      chain_r     <= IV;
    end else begin
      state_r <= state_nxt;
      if (pop && cmd.reload) begin
        chain_r <= IV;
      end else if (state_r == ST_FINAL) begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          chain_r[i] <= chain_r[i] + v_r[i];
        end
      end
      if (pop && cmd.compress) begin
        emit_r <= cmd.emit;
      end
      if (state_r == ST_INIT) begin
        round_r <= '0;
      end else if (state_r == ST_ROUND) begin
        round_r <= round_r + ROUND_W'(1);
      end
      if (state_r == ST_FINAL) begin
        idx_r <= '0;
      end else if (emit_load) begin
        idx_r <= idx_r + DIGEST_W'(1);
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_INIT) begin
      v_r   <= chain_r;
      hkw_r <= chain_r[7] + round_k('0) + w0;
    end else if (state_r == ST_ROUND) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      hkw_r  <= v_r[6] + round_k(round_r + ROUND_W'(1)) + w1;
    end
    if (emit_load) begin
      out_data_r.digest_word  <= chain_r[idx_r];
      out_data_r.digest_index <= idx_r;
      out_data_r.digest_last  <= last_idx;
    end
  end

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (round_r < ROUND_W'(ROUNDS)))
    else $error("round counter out of range");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("digest word presented outside the emit phase");

  a_start_compress: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cmd.compress) |=> (state_r == ST_INIT))
    else $error("last word of a block did not start compression");

endmodule

/* hdl/sha512_compression_core.sv */
// SHA-512 compression core top level, built on shac_pkg, shac_front, shac_sched, shac_engine.
// The sixteenth word of a block passes through the request queue to the engine; setup,
// 80 rounds and the chaining add follow, and for the final block of a message the digest
// words are then presented one word per cycle while the receiver is ready. A 1024-bit
// block is compressed at one round per cycle, while the queue takes requests if it has room.
// Reset: synchronous, active low; empties the queue and loads the SHA-512 initial hash.
module sha512_compression_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  shac_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output shac_pkg::out_rsp_t  out_data
);
  import shac_pkg::*;

  // The front end accepts each request, works out its place in the 1024-bit block
  // and whether it closes a block (and a message), and stores it in a short queue.
  // The engine drains that queue: ordinary words only shift into the schedule window,
  // while the last word of a block starts the 80-round compression. During the rounds
  // and while digest words wait on the output register, the queue keeps taking requests until full.
  logic       cmd_valid;
  logic       cmd_ready;
  cmd_t       cmd;
  sched_ctl_t sched_ctl;
  word_t      w0;
  word_t      w1;

  shac_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // The schedule window holds the block's words in order; during the rounds it
  // produces the expanded schedule, one word per round, at its head.
  shac_sched u_sched (
    .clk     (clk),
    .ctl     (sched_ctl),
    .word_in (cmd.word),
    .w0      (w0),
    .w1      (w1)
  );

  // The engine owns the chaining value and the output register. A reload request
  // restores the initial hash before its word is used.
  shac_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .sched_ctl (sched_ctl),
    .w0        (w0),
    .w1        (w1),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
